// ===== hw/rtl/pfw_pkg.sv =====
// ----------------------------------------------------------------------------
// pfw_pkg
// Shared widths, constants and types for the synthesizer word calculator.
// ----------------------------------------------------------------------------
`default_nettype none

package pfw_pkg;

	// field widths
	localparam int unsigned FREQ_W = 23;
	localparam int unsigned REG0_W = 31;
	localparam int unsigned REG4_W = 32;
	localparam int unsigned EXP_W  = 3;
	localparam int unsigned N_W    = 9;   // N stays below 263
	localparam int unsigned FRAC_W = 12;  // FRAC stays below 4000
	localparam int unsigned NUM_EXP = 8;

	// top of the output band, in kHz, before the divider
	localparam logic [FREQ_W-1:0] TOP_KHZ = 23'd3000000;

	// 32000 = 125 << 8; quotient by 125 uses a 16-bit reciprocal with a 22-bit shift,
	// exact for any 15-bit dividend
	localparam int unsigned COMP_SHIFT   = 8;
	localparam int unsigned RECIP_SHIFT  = 22;
	localparam logic [15:0] RECIP_125    = 16'd33555;

	localparam logic [EXP_W-1:0]  MAX_EXP       = 3'd7;
	localparam logic [REG4_W-1:0] BASE_R4_RESET = 32'h6288_003C;

	// result of one calculation, handed from the solver to the output register
	typedef struct packed {
		logic [REG0_W-1:0] reg0_word;
		logic [REG4_W-1:0] reg4_word;
		logic [EXP_W-1:0]  div_exponent;
		logic [FREQ_W-1:0] actual_khz;
		logic              below_range;
	} pfw_result_t;

endpackage : pfw_pkg

`default_nettype wire

// ===== hw/rtl/pfw_solver.sv =====
// ----------------------------------------------------------------------------
// pfw_solver
// Combinational N / FRAC / divider solver for one requested frequency.
// ----------------------------------------------------------------------------
`default_nettype none

module pfw_solver (
	input  wire logic [pfw_pkg::FREQ_W-1:0] frequency_khz,
	input  wire logic [pfw_pkg::REG4_W-1:0] base_r4,
	output pfw_pkg::pfw_result_t            result
);
	import pfw_pkg::*;

	logic [NUM_EXP-1:0] hit;
	logic [EXP_W-1:0]   exp_sel;
	logic               low;
	logic [29:0]        scaled_wide;
	logic [FREQ_W-1:0]  scaled;
	logic [14:0]        coarse;
	logic [30:0]        prod;
	logic [N_W-1:0]     n_int;
	logic [15:0]        n_x125;
	logic [6:0]         rem_hi;
	logic [FRAC_W-1:0]  frac;
	logic [FREQ_W-1:0]  actual_full;

	// compare against every band edge in parallel
	always_comb begin
		for (int i = 0; i < NUM_EXP; i++) begin
			hit[i] = frequency_khz > (TOP_KHZ >> i);
		end
	end

	// pick the lowest exponent that clears its edge, clamp to the largest otherwise
	always_comb begin
		exp_sel = MAX_EXP;
		for (int i = NUM_EXP - 1; i >= 0; i--) begin
			if (hit[i]) begin
				exp_sel = EXP_W'(i);
			end
		end
		low = ~|hit;
	end

	// scale up; the result always fits in the field width
	assign scaled_wide = {7'd0, frequency_khz} << exp_sel;
	assign scaled      = scaled_wide[FREQ_W-1:0];

	// N = scaled / 32000: drop the 2^8 factor, divide the rest by 125
	assign coarse = scaled[FREQ_W-1:COMP_SHIFT];
	assign prod   = {16'd0, coarse} * {15'd0, RECIP_125};
	assign n_int  = prod[RECIP_SHIFT +: N_W];

	// remainder mod 125 by shift and subtract
	assign n_x125 = {n_int, 7'd0} - {6'd0, n_int, 1'b0} - {7'd0, n_int};
	assign rem_hi = 7'(({1'b0, coarse} - n_x125));

	// FRAC = remainder * 4000 / 32000 = remainder >> 3
	assign frac = {rem_hi, scaled[COMP_SHIFT-1:3]};

	// 32000*N + 8*FRAC is the scaled value with its low three bits cleared
	assign actual_full = {scaled[FREQ_W-1:3], 3'd0} >> exp_sel;

	// pack the words
	always_comb begin
		result.reg0_word    = {7'd0, n_int, frac, 3'd0};
		result.reg4_word    = {base_r4[31:23], exp_sel, base_r4[19:0]};
		result.div_exponent = exp_sel;
		result.actual_khz   = actual_full;
		result.below_range  = low;
	end

endmodule : pfw_solver

`default_nettype wire

// ===== hw/rtl/pll_frequency_word_calc.sv =====
// An accepted beat passes the input register, the solver logic and the output
// register; one beat per cycle unless out_ready stalls the output stage.
// The reciprocal multiply for the divide by 32000 sets the critical path.
// Reset (arst_n low) empties both stages and loads base_r4 with 0x6288003C.
// ----------------------------------------------------------------------------
// pll_frequency_word_calc
// Computes fractional-N programming words and the produced frequency per request.
// ----------------------------------------------------------------------------
`default_nettype none

module pll_frequency_word_calc (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// configuration
	input  wire logic                          cfg_wr_en,
	input  wire logic [pfw_pkg::REG4_W-1:0]    cfg_wr_data,
	// request channel
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [pfw_pkg::FREQ_W-1:0]    frequency_khz,
	// result channel
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [pfw_pkg::REG0_W-1:0]         reg0_word,
	output logic [pfw_pkg::REG4_W-1:0]         reg4_word,
	output logic [pfw_pkg::EXP_W-1:0]          div_exponent,
	output logic [pfw_pkg::FREQ_W-1:0]         actual_khz,
	output logic                               below_range
);
	import pfw_pkg::*;

	logic [REG4_W-1:0] base_r4_q;
	logic              valid_s1;
	logic [FREQ_W-1:0] freq_s1;
	logic              valid_s2;
	pfw_result_t       res_s2;
	pfw_result_t       res_c;
	logic              adv_s2;
	logic              load_s1;

	// handshake: output stage frees when empty or taken
	assign adv_s2   = ~valid_s2 | out_ready;
	assign in_ready = ~valid_s1 | adv_s2;
	assign load_s1  = in_valid & in_ready;

	// hold the register-4 base word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_r4_q <= BASE_R4_RESET;
		end else if (cfg_wr_en) begin
			base_r4_q <= cfg_wr_data;
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			freq_s1 <= frequency_khz;
		end
	end

	pfw_solver u_solver (
		.frequency_khz (freq_s1),
		.base_r4       (base_r4_q),
		.result        (res_c)
	);

	// output stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			res_s2 <= res_c;
		end
	end

	assign out_valid    = valid_s2;
	assign reg0_word    = res_s2.reg0_word;
	assign reg4_word    = res_s2.reg4_word;
	assign div_exponent = res_s2.div_exponent;
	assign actual_khz   = res_s2.actual_khz;
	assign below_range  = res_s2.below_range;

`ifndef ASSERT_OFF
	// a beat in the input stage moves on whenever the output stage frees
	a_s1_to_s2: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && adv_s2) |=> valid_s2)
		else $error("input stage beat not moved to output stage");

	// an accepted request lands in the input stage
	a_accept_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> valid_s1)
		else $error("accepted beat lost");

	// the exponent in the register-4 word matches the reported exponent
	a_r4_exp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (reg4_word[22:20] == div_exponent))
		else $error("register-4 divider field mismatch");

	// the clamp only happens at the largest exponent
	a_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && below_range) |-> (div_exponent == MAX_EXP))
		else $error("below range without clamped exponent");

	// FRAC stays within its modulus and the low bits stay clear
	a_frac: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((reg0_word[14:3] < 12'd4000) && (reg0_word[2:0] == 3'd0)))
		else $error("FRAC field out of range");
`endif

endmodule : pll_frequency_word_calc

`default_nettype wire
